// ===== hdl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants for the least-squares line fit
// Status codes, shared-unit operation codes and the control struct that the
// sequencer hands to the iterative arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

	localparam int XY_W      = 24;
	localparam int OUT_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int DIV_STEPS = 33;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SING = 2'd2;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
		logic sub;
	} alu_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lsf_acc.sv =====
// ----------------------------------------------------------------------------
// lsf_acc: running sums for the line fit
// Keeps the point count and the sums of x, y, x*x and x*y. One 24x24
// multiplier is used twice per point, its product registered before the add.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_acc #(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic                                   clear,
	input  wire logic [lsf_pkg::XY_W-1:0]               x,
	input  wire logic [lsf_pkg::XY_W-1:0]               y,
	output logic                                        busy,
	output logic [$clog2(MAX_POINTS+1)-1:0]             count,
	output logic [lsf_pkg::XY_W+$clog2(MAX_POINTS+1)-1:0]   sum_x,
	output logic [lsf_pkg::XY_W+$clog2(MAX_POINTS+1)-1:0]   sum_y,
	output logic [2*lsf_pkg::XY_W+$clog2(MAX_POINTS+1)-1:0] sum_xx,
	output logic [2*lsf_pkg::XY_W+$clog2(MAX_POINTS+1)-1:0] sum_xy
);

	localparam int CW  = $clog2(MAX_POINTS+1);
	localparam int XW  = lsf_pkg::XY_W;
	localparam int SXW = XW + CW;
	localparam int PRW = 2 * XW;
	localparam int SQW = PRW + CW;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_XX   = 2'd1;
	localparam logic [1:0] PH_XY   = 2'd2;
	localparam logic [1:0] PH_ADD  = 2'd3;

	logic [1:0]            ph_q;
	logic                  keep_q;
	logic signed [XW-1:0]  x_q;
	logic signed [XW-1:0]  y_q;
	logic signed [PRW-1:0] prod_q;
	logic [CW-1:0]         count_q;
	logic [SXW-1:0]        sum_x_q;
	logic [SXW-1:0]        sum_y_q;
	logic [SQW-1:0]        sum_xx_q;
	logic [SQW-1:0]        sum_xy_q;
	logic                  room;

	assign room = (count_q < CW'(MAX_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_IDLE;
			keep_q   <= 1'b0;
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_xy_q <= '0;
		end else if (clear) begin
			ph_q     <= PH_IDLE;
			keep_q   <= 1'b0;
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_xy_q <= '0;
		end else begin
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						keep_q <= room;
						ph_q   <= PH_XX;
						if (room) begin
							count_q <= count_q + 1'b1;
							sum_x_q <= sum_x_q + {{CW{x[XW-1]}}, x};
							sum_y_q <= sum_y_q + {{CW{y[XW-1]}}, y};
						end
					end
				end
				PH_XX: begin
					ph_q <= PH_XY;
				end
				PH_XY: begin
					if (keep_q) begin
						sum_xx_q <= sum_xx_q + {{CW{prod_q[PRW-1]}}, prod_q};
					end
					ph_q <= PH_ADD;
				end
				PH_ADD: begin
					if (keep_q) begin
						sum_xy_q <= sum_xy_q + {{CW{prod_q[PRW-1]}}, prod_q};
					end
					ph_q <= PH_IDLE;
				end
				default: begin
					ph_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			x_q <= x;
			y_q <= y;
		end
		if (ph_q == PH_XX) begin
			prod_q <= x_q * x_q;
		end else if (ph_q == PH_XY) begin
			prod_q <= x_q * y_q;
		end
	end

	assign busy   = (ph_q != PH_IDLE);
	assign count  = count_q;
	assign sum_x  = sum_x_q;
	assign sum_y  = sum_y_q;
	assign sum_xx = sum_xx_q;
	assign sum_xy = sum_xy_q;

endmodule

`default_nettype wire

// ===== hdl/lsf_alu.sv =====
// ----------------------------------------------------------------------------
// lsf_alu: shared iterative arithmetic unit
// Multiply-accumulate by shift and add, one multiplier bit a cycle, and
// rounded, saturating division by restoring steps, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_alu #(
	parameter int OPW       = 61,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lsf_pkg::alu_ctl_t                 ctl,
	input  wire logic [OPW-1:0]                    a,
	input  wire logic [OPW-1:0]                    b,
	input  wire logic [2*OPW-1:0]                  addend,
	input  wire logic [2*OPW+FRAC_BITS-1:0]        num,
	input  wire logic [2*OPW-1:0]                  den,
	output logic                                   busy,
	output logic                                   done,
	output logic [2*OPW-1:0]                       prod_res,
	output logic [lsf_pkg::OUT_W-1:0]              quot
);

	localparam int PW   = 2 * OPW;
	localparam int NW   = PW + FRAC_BITS;
	localparam int QW   = lsf_pkg::DIV_STEPS;
	localparam int RW   = PW + QW;
	localparam int OW   = lsf_pkg::OUT_W;
	localparam int CNTW = $clog2(OPW+1);

	logic            busy_q;
	logic            done_q;
	logic            op_q;
	logic            neg_q;
	logic [CNTW-1:0] cnt_q;
	logic [OPW-1:0]  ma_q;
	logic [PW-1:0]   prod_q;
	logic [PW-1:0]   add_q;
	logic [RW-1:0]   r_q;
	logic [RW-1:0]   dsh_q;
	logic [QW-1:0]   q_q;
	logic [PW-1:0]   res_q;
	logic [OW-1:0]   quo_q;

	logic [OPW:0]    step_sum;
	logic [RW-1:0]   num_x;
	logic [RW-1:0]   den_x;
	logic [OW-1:0]   lim;
	logic [OW-1:0]   sat;

	assign step_sum = {1'b0, prod_q[PW-1:OPW]} + (prod_q[0] ? {1'b0, ma_q} : '0);
	assign num_x    = {{(RW-NW){num[NW-1]}}, num};
	assign den_x    = {{(RW-PW){1'b0}}, den};
	assign lim      = neg_q ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
	assign sat      = (q_q > {{(QW-OW){1'b0}}, lim}) ? lim : q_q[OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= lsf_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (ctl.start) begin
					busy_q <= 1'b1;
					op_q   <= ctl.op;
					cnt_q  <= (ctl.op == lsf_pkg::OP_DIV) ? CNTW'(QW) : CNTW'(OPW);
				end
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (ctl.start) begin
				if (ctl.op == lsf_pkg::OP_DIV) begin
					neg_q <= num[NW-1];
					r_q   <= num[NW-1] ? den_x - (num_x << 1) : den_x + (num_x << 1);
					dsh_q <= {den, {QW{1'b0}}};
					q_q   <= '0;
				end else begin
					neg_q  <= a[OPW-1] ^ b[OPW-1] ^ ctl.sub;
					ma_q   <= a[OPW-1] ? OPW'(0) - a : a;
					prod_q <= {{OPW{1'b0}}, (b[OPW-1] ? OPW'(0) - b : b)};
					add_q  <= addend;
				end
			end
		end else if (cnt_q != '0) begin
			if (op_q == lsf_pkg::OP_DIV) begin
				if (r_q >= dsh_q) begin
					r_q <= r_q - dsh_q;
					q_q <= {q_q[QW-2:0], 1'b1};
				end else begin
					q_q <= {q_q[QW-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end else begin
				prod_q <= {step_sum, prod_q[OPW-1:1]};
			end
		end else begin
			if (op_q == lsf_pkg::OP_DIV) begin
				quo_q <= neg_q ? OW'(0) - sat : sat;
			end else begin
				res_q <= neg_q ? add_q - prod_q : add_q + prod_q;
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign prod_res = res_q;
	assign quot     = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("lsf_alu: start while busy");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0) |=> (done_q && !busy_q))
		else $error("lsf_alu: final step did not complete");

endmodule

`default_nettype wire

// ===== hdl/least_squares_line_fit.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit: least-squares line fit over a run of points
// Points (x, y) arrive on the pt channel; the beat with last set closes the
// run and one beat with slope, intercept and status leaves on the fit channel.
// For each accepted point the accumulator steps through its phases, in which
// the single 24x24 multiplier forms x*x and x*y into the running sums, and
// the sequencer then returns to idle. pt_stall is high from the accepting
// edge until that return and for the whole fit. The fit runs six products
// and two divisions through one shared unit: each product works through
// OPW = 48 + clog2(MAX_POINTS+1) multiplier bits, one multiplier bit a
// cycle, and each division forms 33 quotient bits. Runs of fewer than two
// points finish at once, runs with all x equal straight after the first two
// products. Points past MAX_POINTS are not summed; last still closes the run.
// The result sits in an output register until taken; while fit_stall is high
// the payload holds and a following fit waits for that register to empty.
// Reset clears the sums and count and drops fit_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit #(
	parameter int MAX_POINTS = 4096,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 pt_valid,
	output logic                                      pt_stall,
	input  wire logic signed [lsf_pkg::XY_W-1:0]      x,
	input  wire logic signed [lsf_pkg::XY_W-1:0]      y,
	input  wire logic                                 last,
	output logic                                      fit_valid,
	input  wire logic                                 fit_stall,
	output logic signed [lsf_pkg::OUT_W-1:0]          slope,
	output logic signed [lsf_pkg::OUT_W-1:0]          intercept,
	output logic [lsf_pkg::STATUS_W-1:0]              status
);

	localparam int CW  = $clog2(MAX_POINTS+1);
	localparam int XW  = lsf_pkg::XY_W;
	localparam int SXW = XW + CW;
	localparam int OPW = 2 * XW + CW;
	localparam int PW  = 2 * OPW;
	localparam int NW  = PW + FRAC_BITS;
	localparam int OW  = lsf_pkg::OUT_W;
	localparam int SW  = lsf_pkg::STATUS_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ACC  = 4'd1;
	localparam logic [3:0] S_M1   = 4'd2;
	localparam logic [3:0] S_M2   = 4'd3;
	localparam logic [3:0] S_M3   = 4'd4;
	localparam logic [3:0] S_M4   = 4'd5;
	localparam logic [3:0] S_M5   = 4'd6;
	localparam logic [3:0] S_M6   = 4'd7;
	localparam logic [3:0] S_V1   = 4'd8;
	localparam logic [3:0] S_V2   = 4'd9;
	localparam logic [3:0] S_PUT  = 4'd10;

	logic [3:0]     state_q;
	logic           last_q;
	logic           go_q;
	logic [PW-1:0]  t_q;
	logic [PW-1:0]  d_q;
	logic [PW-1:0]  ns_q;
	logic [PW-1:0]  ni_q;
	logic [OW-1:0]  r_slope_q;
	logic [OW-1:0]  r_icpt_q;
	logic [SW-1:0]  r_status_q;
	logic           fit_valid_q;
	logic [OW-1:0]  slope_q;
	logic [OW-1:0]  intercept_q;
	logic [SW-1:0]  status_q;

	logic           pt_take;
	logic           put_load;

	logic           acc_busy;
	logic [CW-1:0]  acc_count;
	logic [SXW-1:0] acc_sx;
	logic [SXW-1:0] acc_sy;
	logic [OPW-1:0] acc_sxx;
	logic [OPW-1:0] acc_sxy;

	logic [OPW-1:0] n_op;
	logic [OPW-1:0] sx_op;
	logic [OPW-1:0] sy_op;

	lsf_pkg::alu_ctl_t alu_ctl;
	logic [OPW-1:0] alu_a;
	logic [OPW-1:0] alu_b;
	logic [PW-1:0]  alu_addend;
	logic [NW-1:0]  alu_num;
	logic           alu_busy;
	logic           alu_done;
	logic [PW-1:0]  alu_res;
	logic [OW-1:0]  alu_quot;

	assign pt_stall = (state_q != S_IDLE);
	assign pt_take  = pt_valid && !pt_stall;
	assign put_load = (state_q == S_PUT) && (!fit_valid_q || !fit_stall);

	lsf_acc #(
		.MAX_POINTS(MAX_POINTS)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pt_take),
		.clear  (put_load),
		.x      (x),
		.y      (y),
		.busy   (acc_busy),
		.count  (acc_count),
		.sum_x  (acc_sx),
		.sum_y  (acc_sy),
		.sum_xx (acc_sxx),
		.sum_xy (acc_sxy)
	);

	assign n_op  = {{(OPW-CW){1'b0}}, acc_count};
	assign sx_op = {{(OPW-SXW){acc_sx[SXW-1]}}, acc_sx};
	assign sy_op = {{(OPW-SXW){acc_sy[SXW-1]}}, acc_sy};

	always_comb begin
		alu_ctl.start = go_q;
		alu_ctl.op    = lsf_pkg::OP_MUL;
		alu_ctl.sub   = 1'b0;
		alu_a         = '0;
		alu_b         = '0;
		alu_addend    = '0;
		alu_num       = '0;
		case (state_q)
			S_M1: begin
				alu_a = n_op;
				alu_b = acc_sxx;
			end
			S_M2: begin
				alu_a       = sx_op;
				alu_b       = sx_op;
				alu_addend  = t_q;
				alu_ctl.sub = 1'b1;
			end
			S_M3: begin
				alu_a = n_op;
				alu_b = acc_sxy;
			end
			S_M4: begin
				alu_a       = sx_op;
				alu_b       = sy_op;
				alu_addend  = t_q;
				alu_ctl.sub = 1'b1;
			end
			S_M5: begin
				alu_a = sy_op;
				alu_b = acc_sxx;
			end
			S_M6: begin
				alu_a       = sx_op;
				alu_b       = acc_sxy;
				alu_addend  = t_q;
				alu_ctl.sub = 1'b1;
			end
			S_V1: begin
				alu_ctl.op = lsf_pkg::OP_DIV;
				alu_num    = {ns_q, {FRAC_BITS{1'b0}}};
			end
			S_V2: begin
				alu_ctl.op = lsf_pkg::OP_DIV;
				alu_num    = {{FRAC_BITS{ni_q[PW-1]}}, ni_q};
			end
			default: begin
				alu_ctl.start = go_q;
			end
		endcase
	end

	lsf_alu #(
		.OPW       (OPW),
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (alu_ctl),
		.a        (alu_a),
		.b        (alu_b),
		.addend   (alu_addend),
		.num      (alu_num),
		.den      (d_q),
		.busy     (alu_busy),
		.done     (alu_done),
		.prod_res (alu_res),
		.quot     (alu_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pt_take) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (!acc_busy) begin
						if (!last_q) begin
							state_q <= S_IDLE;
						end else if (acc_count < CW'(2)) begin
							state_q <= S_PUT;
						end else begin
							state_q <= S_M1;
							go_q    <= 1'b1;
						end
					end
				end
				S_M1, S_M3, S_M4, S_M5, S_M6, S_V1: begin
					if (alu_done) begin
						state_q <= state_q + 4'd1;
						go_q    <= 1'b1;
					end
				end
				S_M2: begin
					if (alu_done) begin
						if (alu_res == '0) begin
							state_q <= S_PUT;
						end else begin
							state_q <= S_M3;
							go_q    <= 1'b1;
						end
					end
				end
				S_V2: begin
					if (alu_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (put_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pt_take) begin
			last_q <= last;
		end
		case (state_q)
			S_ACC: begin
				r_slope_q  <= '0;
				r_icpt_q   <= '0;
				r_status_q <= (acc_count < CW'(2)) ? lsf_pkg::ST_FEW : lsf_pkg::ST_OK;
			end
			S_M1, S_M3, S_M5: begin
				if (alu_done) begin
					t_q <= alu_res;
				end
			end
			S_M2: begin
				if (alu_done) begin
					d_q <= alu_res;
					if (alu_res == '0) begin
						r_status_q <= lsf_pkg::ST_SING;
					end
				end
			end
			S_M4: begin
				if (alu_done) begin
					ns_q <= alu_res;
				end
			end
			S_M6: begin
				if (alu_done) begin
					ni_q <= alu_res;
				end
			end
			S_V1: begin
				if (alu_done) begin
					r_slope_q <= alu_quot;
				end
			end
			S_V2: begin
				if (alu_done) begin
					r_icpt_q <= alu_quot;
				end
			end
			default: begin
				r_status_q <= r_status_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_valid_q <= 1'b0;
		end else if (put_load) begin
			fit_valid_q <= 1'b1;
		end else if (!fit_stall) begin
			fit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_load) begin
			slope_q     <= r_slope_q;
			intercept_q <= r_icpt_q;
			status_q    <= r_status_q;
		end
	end

	assign fit_valid = fit_valid_q;
	assign slope     = slope_q;
	assign intercept = intercept_q;
	assign status    = status_q;

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(fit_valid_q && status_q != lsf_pkg::ST_OK) |-> (slope_q == '0 && intercept_q == '0))
		else $error("least_squares_line_fit: non-zero result on failed fit");

	a_clear_after_put: assert property (@(posedge clk) disable iff (!arst_n)
		put_load |=> (acc_count == '0 && state_q == S_IDLE && fit_valid_q))
		else $error("least_squares_line_fit: run not cleared after result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_count <= CW'(MAX_POINTS))
		else $error("least_squares_line_fit: point count beyond limit");

	a_alu_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_ACC || state_q == S_PUT) |-> !alu_busy)
		else $error("least_squares_line_fit: shared unit busy outside the fit");

endmodule

`default_nettype wire
